[sv/ssvf_pkg.sv]
`timescale 1ns / 1ps
package ssvf_pkg;

  // Saturation width of the two integrators.
  localparam int SatBits = 17;

  // Port field widths.
  localparam int SampleW = 16;
  localparam int CutW    = 14;
  localparam int DampW   = 15;
  localparam int CfgW    = 15;
  localparam int HighW   = 18;
  localparam int BandW   = 17;
  localparam int LowW    = 17;
  localparam int SoftW   = 17;

  // Internal widths, all derived from the saturation width.
  localparam int HpW    = ((SatBits > 16) ? SatBits : 16) + 2;  // high-pass value
  localparam int MagW   = HpW;                                  // multiplicand magnitude
  localparam int SqW    = ((SatBits - 1) > 16) ? (SatBits - 1) : 16;
  localparam int NumDig = (SqW + 1) / 2;                        // radix-4 digits
  localparam int MplW   = 2 * NumDig;                           // multiplier operand
  localparam int ProdW  = MagW + MplW;
  localparam int CntW   = (NumDig > 1) ? $clog2(NumDig) : 1;
  localparam int SumW   = HpW + 1;                              // integrator update sum

  localparam int ClipHalf = 32768;

  // Configuration register indexes.
  localparam logic RegCutoff  = 1'b0;
  localparam logic RegDamping = 1'b1;

  localparam logic [DampW-1:0] DampReset = '1;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_GO,
    ST_RUN,
    ST_OUT
  } state_e;

  // Which multiply the sequencer is on.
  typedef enum logic [1:0] {
    PH_BD,  // band * damping
    PH_HW,  // high * cutoff
    PH_BW,  // new band * cutoff
    PH_SQ   // soft clipper square
  } phase_e;

  function automatic logic signed [SatBits-1:0] sat(input logic signed [SumW-1:0] v);
    logic [SumW-SatBits:0] top;
    top = v[SumW-1:SatBits-1];
    if (top == '0 || top == '1) begin
      return v[SatBits-1:0];
    end else if (v[SumW-1]) begin
      return {1'b1, {(SatBits-1){1'b0}}};
    end else begin
      return {1'b0, {(SatBits-1){1'b1}}};
    end
  endfunction

endpackage

[sv/ssvf_mul.sv]
`timescale 1ns / 1ps
// Radix-4 shift-add multiplier, unsigned. Two multiplier bits per cycle,
// product low bits shift into the multiplier register as it empties.
module ssvf_mul (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [ssvf_pkg::MagW-1:0]     mcand_i,
  input  logic [ssvf_pkg::MplW-1:0]     mplier_i,
  output logic                          done_o,
  output logic [ssvf_pkg::ProdW-1:0]    prod_o
);

  localparam int MagW = ssvf_pkg::MagW;
  localparam int MplW = ssvf_pkg::MplW;
  localparam int CntW = ssvf_pkg::CntW;
  localparam int AccW = MagW + 2;

  logic                busy_q, busy_d;
  logic                done_q, done_d;
  logic [CntW-1:0]     cnt_q, cnt_d;
  logic [MagW-1:0]     mc_q, mc_d;
  logic [MagW-1:0]     hi_q, hi_d;
  logic [MplW-1:0]     lo_q, lo_d;
  logic [AccW-1:0]     pp;
  logic [AccW-1:0]     sum;

  always_comb begin
    pp = '0;
    if (lo_q[0]) begin
      pp = pp + AccW'(mc_q);
    end
    if (lo_q[1]) begin
      pp = pp + {1'b0, mc_q, 1'b0};
    end
    sum = AccW'(hi_q) + pp;

    busy_d = busy_q;
    done_d = 1'b0;
    cnt_d  = cnt_q;
    mc_d   = mc_q;
    hi_d   = hi_q;
    lo_d   = lo_q;
    if (start_i) begin
      busy_d = 1'b1;
      cnt_d  = '0;
      mc_d   = mcand_i;
      hi_d   = '0;
      lo_d   = mplier_i;
    end else if (busy_q) begin
      hi_d  = sum[AccW-1:2];
      lo_d  = {sum[1:0], lo_q[MplW-1:2]};
      cnt_d = cnt_q + 1'b1;
      if (cnt_q == CntW'(ssvf_pkg::NumDig - 1)) begin
        busy_d = 1'b0;
        done_d = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      busy_q <= busy_d;
      done_q <= done_d;
      cnt_q  <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mc_q <= mc_d;
    hi_q <= hi_d;
    lo_q <= lo_d;
  end

  assign done_o = done_q;
  assign prod_o = {hi_q, lo_q};

endmodule

[sv/saturating_state_variable_filter_core.sv]
`timescale 1ns / 1ps
// Saturating Chamberlin state variable filter, one audio sample per transaction.
//
// Input channel: in_valid_i / in_stall_o with sample_in_i (16-bit signed).
// Output channel: out_valid_o / out_stall_i with high_out_o, band_out_o,
// low_out_o and soft_low_out_o. A transaction moves when valid is high and
// stall is low. Configuration: cfg_we_i writes cfg_data_i to register
// cfg_index_i (0 = cutoff w, 1 = damping d); write only while idle.
//
// Every sample runs four unsigned multiplies on one radix-4 shift-add unit
// (two bits per cycle): band*d, high*w, new band*w, and the clipper square.
// A multiply is a start, NumDig = 8 digit steps and a result write-back.
// A new sample is taken only once the previous one has left the output step;
// the multiplier loop sets the rate.
//
// The output register holds a finished result while the receiver stalls; the
// next sample is already accepted and computed meanwhile, and only waits in
// the output step until the register frees up.
// Reset clears both integrators, sets w = 0 and d = 32767, and empties the
// output register.
module saturating_state_variable_filter_core (
  input  logic                                   clk_i,
  input  logic                                   rst_ni,
  input  logic                                   cfg_we_i,
  input  logic [0:0]                             cfg_index_i,
  input  logic [ssvf_pkg::CfgW-1:0]              cfg_data_i,
  input  logic                                   in_valid_i,
  output logic                                   in_stall_o,
  input  logic signed [ssvf_pkg::SampleW-1:0]    sample_in_i,
  output logic                                   out_valid_o,
  input  logic                                   out_stall_i,
  output logic signed [ssvf_pkg::HighW-1:0]      high_out_o,
  output logic signed [ssvf_pkg::BandW-1:0]      band_out_o,
  output logic signed [ssvf_pkg::LowW-1:0]       low_out_o,
  output logic signed [ssvf_pkg::SoftW-1:0]      soft_low_out_o
);

  localparam int SatBits = ssvf_pkg::SatBits;
  localparam int HpW     = ssvf_pkg::HpW;
  localparam int MagW    = ssvf_pkg::MagW;
  localparam int MplW    = ssvf_pkg::MplW;
  localparam int ProdW   = ssvf_pkg::ProdW;
  localparam int SumW    = ssvf_pkg::SumW;
  localparam int SoftW   = ssvf_pkg::SoftW;

  localparam logic signed [MagW-1:0] ClipHalfM = MagW'(ssvf_pkg::ClipHalf);
  localparam logic [SoftW-1:0]       ClipHalfS = SoftW'(ssvf_pkg::ClipHalf);

  ssvf_pkg::state_e st_q, st_d;
  ssvf_pkg::phase_e ph_q, ph_d;

  // Config and filter state
  logic [ssvf_pkg::CutW-1:0]          cut_q;
  logic [ssvf_pkg::DampW-1:0]         damp_q;
  logic signed [SatBits-1:0]          bp_q, lp_q;

  // Per-sample working registers
  logic signed [ssvf_pkg::SampleW-1:0] x_q;
  logic signed [HpW-1:0]               hp_q;
  logic                                neg_q;
  logic [SoftW-1:0]                    soft_q;

  // Output register
  logic                               out_valid_q, out_valid_d;
  logic [ssvf_pkg::HighW-1:0]         high_q;
  logic [ssvf_pkg::BandW-1:0]         band_q;
  logic [ssvf_pkg::LowW-1:0]          low_q;
  logic [SoftW-1:0]                   soft_out_q;

  logic                               mul_start;
  logic                               mul_done;
  logic [ProdW-1:0]                   mul_prod;
  logic [MagW-1:0]                    op_mag;
  logic [MplW-1:0]                    op_mpl;

  logic                               accept;
  logic                               out_free;
  logic                               run_done;

  // Operand selection
  logic signed [SatBits-1:0]          lp_adj, s_half;
  logic                               s_neg;
  logic signed [MagW-1:0]             s_ext, t_val, op_s;
  logic                               neg_go;

  // Write-back arithmetic
  logic [HpW-1:0]                     q_bd, q_w;
  logic signed [HpW-1:0]              bd_s, hp_new;
  logic signed [SumW-1:0]             q_ws, q_sgn, acc;
  logic signed [SatBits-1:0]          acc_src, sat_val;
  logic [SoftW-1:0]                   q_sq, soft_new;

  assign accept   = in_valid_i && (st_q == ssvf_pkg::ST_IDLE);
  assign out_free = !out_valid_q || !out_stall_i;
  assign run_done = (st_q == ssvf_pkg::ST_RUN) && mul_done;

  // Soft clipper input: s = low/2 toward zero, t = 32768 -/+ s
  always_comb begin
    lp_adj = lp_q + $signed({{(SatBits-1){1'b0}}, lp_q[SatBits-1]});
    s_half = lp_adj >>> 1;
    s_neg  = s_half[SatBits-1];
    s_ext  = MagW'(s_half);
    t_val  = s_neg ? (s_ext + ClipHalfM) : (ClipHalfM - s_ext);
  end

  always_comb begin
    unique case (ph_q) inside
      ssvf_pkg::PH_BD, ssvf_pkg::PH_BW: op_s = MagW'(bp_q);
      ssvf_pkg::PH_HW:                  op_s = hp_q;
      ssvf_pkg::PH_SQ:                  op_s = t_val;
      default:                          op_s = '0;
    endcase
    op_mag = op_s[MagW-1] ? (~op_s + 1'b1) : op_s;
    unique case (ph_q)
      ssvf_pkg::PH_BD: op_mpl = MplW'(damp_q);
      ssvf_pkg::PH_SQ: op_mpl = op_mag[MplW-1:0];
      default:         op_mpl = MplW'(cut_q);
    endcase
    neg_go = (ph_q == ssvf_pkg::PH_SQ) ? s_neg : op_s[MagW-1];
  end

  ssvf_mul u_mul (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (mul_start),
    .mcand_i  (op_mag),
    .mplier_i (op_mpl),
    .done_o   (mul_done),
    .prod_o   (mul_prod)
  );

  // Product scaling and sign restore; divisions truncate toward zero since
  // the shift acts on the magnitude.
  always_comb begin
    q_bd   = mul_prod[16 +: HpW];
    bd_s   = neg_q ? -$signed(q_bd) : $signed(q_bd);
    hp_new = HpW'(x_q) - bd_s + HpW'(lp_q);

    q_w     = mul_prod[14 +: HpW];
    q_ws    = $signed({1'b0, q_w});
    q_sgn   = neg_q ? -q_ws : q_ws;
    acc_src = (ph_q == ssvf_pkg::PH_HW) ? bp_q : lp_q;
    acc     = SumW'(acc_src) + q_sgn;
    sat_val = ssvf_pkg::sat(acc);

    q_sq     = mul_prod[15 +: SoftW];
    soft_new = neg_q ? (q_sq - ClipHalfS) : (ClipHalfS - q_sq);
  end

  // Sequencer
  always_comb begin
    st_d      = st_q;
    ph_d      = ph_q;
    mul_start = 1'b0;
    unique case (st_q)
      ssvf_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          st_d = ssvf_pkg::ST_GO;
          ph_d = ssvf_pkg::PH_BD;
        end
      end
      ssvf_pkg::ST_GO: begin
        mul_start = 1'b1;
        st_d      = ssvf_pkg::ST_RUN;
      end
      ssvf_pkg::ST_RUN: begin
        if (mul_done) begin
          st_d = ssvf_pkg::ST_GO;
          unique case (ph_q)
            ssvf_pkg::PH_BD: ph_d = ssvf_pkg::PH_HW;
            ssvf_pkg::PH_HW: ph_d = ssvf_pkg::PH_BW;
            ssvf_pkg::PH_BW: ph_d = ssvf_pkg::PH_SQ;
            ssvf_pkg::PH_SQ: st_d = ssvf_pkg::ST_OUT;
            default:         ph_d = ssvf_pkg::PH_BD;
          endcase
        end
      end
      ssvf_pkg::ST_OUT: begin
        if (out_free) begin
          st_d = ssvf_pkg::ST_IDLE;
        end
      end
      default: st_d = ssvf_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    out_valid_d = out_valid_q;
    if ((st_q == ssvf_pkg::ST_OUT) && out_free) begin
      out_valid_d = 1'b1;
    end else if (!out_stall_i) begin
      out_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ssvf_pkg::ST_IDLE;
      ph_q        <= ssvf_pkg::PH_BD;
      out_valid_q <= 1'b0;
      cut_q       <= '0;
      damp_q      <= ssvf_pkg::DampReset;
      bp_q        <= '0;
      lp_q        <= '0;
    end else begin
      st_q        <= st_d;
      ph_q        <= ph_d;
      out_valid_q <= out_valid_d;
      if (cfg_we_i) begin
        unique case (cfg_index_i)
          ssvf_pkg::RegCutoff:  cut_q  <= cfg_data_i[ssvf_pkg::CutW-1:0];
          ssvf_pkg::RegDamping: damp_q <= cfg_data_i[ssvf_pkg::DampW-1:0];
          default:              ;
        endcase
      end
      if (run_done && (ph_q == ssvf_pkg::PH_HW)) begin
        bp_q <= sat_val;
      end
      if (run_done && (ph_q == ssvf_pkg::PH_BW)) begin
        lp_q <= sat_val;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      x_q <= sample_in_i;
    end
    if (st_q == ssvf_pkg::ST_GO) begin
      neg_q <= neg_go;
    end
    if (run_done && (ph_q == ssvf_pkg::PH_BD)) begin
      hp_q <= hp_new;
    end
    if (run_done && (ph_q == ssvf_pkg::PH_SQ)) begin
      soft_q <= soft_new;
    end
    if ((st_q == ssvf_pkg::ST_OUT) && out_free) begin
      high_q     <= hp_q[ssvf_pkg::HighW-1:0];
      band_q     <= ssvf_pkg::BandW'(bp_q);
      low_q      <= ssvf_pkg::LowW'(lp_q);
      soft_out_q <= soft_q;
    end
  end

  assign in_stall_o     = (st_q != ssvf_pkg::ST_IDLE);
  assign out_valid_o    = out_valid_q;
  assign high_out_o     = high_q;
  assign band_out_o     = band_q;
  assign low_out_o      = low_q;
  assign soft_low_out_o = soft_out_q;

`ifndef ASSERT_OFF
  a_accept_starts: assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_valid_i && !in_stall_o |=> st_q == ssvf_pkg::ST_GO && ph_q == ssvf_pkg::PH_BD)
    else $error("accepted sample did not start the band*d multiply");

  a_done_in_run: assert property (@(posedge clk_i) disable iff (!rst_ni)
    mul_done |-> st_q == ssvf_pkg::ST_RUN)
    else $error("multiplier finished outside the run step");

  a_result_from_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_o) |-> $past(st_q) == ssvf_pkg::ST_OUT)
    else $error("output became valid without passing the output step");

  a_idle_mul_quiet: assert property (@(posedge clk_i) disable iff (!rst_ni)
    st_q == ssvf_pkg::ST_IDLE |-> !mul_done)
    else $error("multiplier still finishing while idle");
`endif

endmodule
